### design/mhb_pkg.sv
`default_nettype none

package mhb_pkg;

    localparam logic [2:0] REG_MASK_SHAPE    = 3'd0;
    localparam logic [2:0] REG_BLEND_MODE    = 3'd1;
    localparam logic [2:0] REG_FEATHER_CELLS = 3'd2;
    localparam logic [2:0] REG_REGION_WIDTH  = 3'd3;
    localparam logic [2:0] REG_REGION_DEPTH  = 3'd4;

    localparam logic [1:0] MODE_REPLACE = 2'd0;
    localparam logic [1:0] MODE_RAISE   = 2'd1;
    localparam logic [1:0] MODE_LOWER   = 2'd2;

    localparam logic [15:0] FULL_WEIGHT = 16'hFFFF;

    localparam int ST_IN       = 0;
    localparam int ST_MUL      = 1;
    localparam int ST_AXDIV    = 2;
    localparam int AXDIV_STEPS = 32;
    localparam int ST_SUM      = ST_AXDIV + AXDIV_STEPS;
    localparam int ST_SQRT     = ST_SUM + 1;
    localparam int SQRT_STEPS  = 16;
    localparam int ST_INWARD   = ST_SQRT + SQRT_STEPS;
    localparam int ST_PREP     = ST_INWARD + 1;
    localparam int ST_FDIV     = ST_PREP + 1;
    localparam int FDIV_STEPS  = 16;
    localparam int ST_WEIGHT   = ST_FDIV + FDIV_STEPS;
    localparam int ST_BLEND    = ST_WEIGHT + 1;
    localparam int ST_RESULT   = ST_BLEND + 1;
    localparam int NUM_STAGES  = ST_RESULT + 1;

    typedef struct packed {
        logic        mask_shape;
        logic [1:0]  blend_mode;
        logic [15:0] feather_cells;
        logic [15:0] region_width;
        logic [15:0] region_depth;
    } cfg_t;

    typedef struct packed {
        logic [15:0] src;
        logic [15:0] gen;
        logic        in_rgn;
        logic [15:0] d;
        logic [15:0] ax;
        logic [15:0] az;
        logic [31:0] divx;
        logic [31:0] divz;
        logic [31:0] remx;
        logic [31:0] remz;
        logic [31:0] qx;
        logic [31:0] qz;
        logic [32:0] rnum;
        logic [15:0] m;
        logic [31:0] r2;
        logic        outside;
        logic [17:0] srem;
        logic [15:0] root;
        logic [31:0] inward;
        logic        full;
        logic [32:0] num;
        logic [16:0] den;
        logic [16:0] frem;
        logic [15:0] fq;
        logic [15:0] w;
        logic [31:0] v;
        logic [15:0] res;
    } stage_t;

endpackage

`default_nettype wire

### design/mhb_regs.sv
`default_nettype none

module mhb_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output mhb_pkg::cfg_t      cfg
);
    import mhb_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[4:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mask_shape    <= 1'b0;
            cfg_reg.blend_mode    <= MODE_REPLACE;
            cfg_reg.feather_cells <= 16'd0;
            cfg_reg.region_width  <= 16'd1;
            cfg_reg.region_depth  <= 16'd1;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_MASK_SHAPE:    cfg_reg.mask_shape    <= pwdata[0];
                REG_BLEND_MODE:    cfg_reg.blend_mode    <= pwdata[1:0];
                REG_FEATHER_CELLS: cfg_reg.feather_cells <= pwdata[15:0];
                REG_REGION_WIDTH:  cfg_reg.region_width  <= pwdata[15:0];
                REG_REGION_DEPTH:  cfg_reg.region_depth  <= pwdata[15:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_MASK_SHAPE:    prdata = {31'd0, cfg_reg.mask_shape};
            REG_BLEND_MODE:    prdata = {30'd0, cfg_reg.blend_mode};
            REG_FEATHER_CELLS: prdata = {16'd0, cfg_reg.feather_cells};
            REG_REGION_WIDTH:  prdata = {16'd0, cfg_reg.region_width};
            REG_REGION_DEPTH:  prdata = {16'd0, cfg_reg.region_depth};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### design/masked_heightmap_blend_top.sv
`default_nettype none

// Blends a generated heightmap into source terrain under a rectangle or ellipse mask, one cell
// per word. A word is accepted in every cycle that the output side keeps up. The pipeline has 72
// stages and holds a 32-step divider for the ellipse axes, a 16-step square root and a 16-step
// divider for the feather weight, followed by an output register with a one-word skid buffer.
// Configuration must be written through the APB port only while no word is in flight; the
// block itself does not enforce it.

module masked_heightmap_blend_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: local_x, local_z, source_height, generated_height.
    input  logic [63:0] s_tdata,
    // Fields from bit 0: in_region.
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: out_height, mask_weight.
    output logic [31:0] m_tdata,
    // Fields from bit 0: masked, feathered, modified.
    output logic [2:0]  m_tuser
);
    import mhb_pkg::*;

    cfg_t                  cfg;
    stage_t                pipe_q [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  pipe_en;
    logic                  main_vld_reg;
    logic                  skid_vld_reg;
    logic [31:0]           main_data_reg;
    logic [31:0]           skid_data_reg;
    logic [2:0]            main_user_reg;
    logic [2:0]            skid_user_reg;
    logic [31:0]           out_data;
    logic [2:0]            out_user;
    logic                  out_vld;

    mhb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign pipe_en  = !skid_vld_reg;
    assign s_tready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_tvalid};
        end
    end

    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_stage
        stage_t st_reg;
        stage_t st_next;

        if (k == ST_IN)
        begin : g_in
            logic [15:0] x;
            logic [15:0] z;
            logic [17:0] tx;
            logic [17:0] tz;
            logic [15:0] mn;
            logic [15:0] ex;
            logic [15:0] ez;
            always_comb
            begin
                st_next        = '0;
                x              = s_tdata[15:0];
                z              = s_tdata[31:16];
                st_next.src    = s_tdata[47:32];
                st_next.gen    = s_tdata[63:48];
                st_next.in_rgn = s_tuser[0] && (x < cfg.region_width) && (z < cfg.region_depth);
                tx = {1'b0, x, 1'b1} - {2'b00, cfg.region_width};
                tz = {1'b0, z, 1'b1} - {2'b00, cfg.region_depth};
                st_next.ax = tx[17] ? 16'(18'd0 - tx) : tx[15:0];
                st_next.az = tz[17] ? 16'(18'd0 - tz) : tz[15:0];
                ex = cfg.region_width - 16'd1 - x;
                ez = cfg.region_depth - 16'd1 - z;
                mn = x;
                if (z < mn)
                begin
                    mn = z;
                end
                if (ex < mn)
                begin
                    mn = ex;
                end
                if (ez < mn)
                begin
                    mn = ez;
                end
                st_next.d = mn;
            end
        end
        else if (k == ST_MUL)
        begin : g_mul
            logic [16:0] d1;
            always_comb
            begin
                st_next      = pipe_q[k-1];
                st_next.remx = 32'(st_next.ax) * 32'(st_next.ax);
                st_next.remz = 32'(st_next.az) * 32'(st_next.az);
                st_next.divx = 32'(cfg.region_width) * 32'(cfg.region_width);
                st_next.divz = 32'(cfg.region_depth) * 32'(cfg.region_depth);
                st_next.qx   = 32'd0;
                st_next.qz   = 32'd0;
                d1           = {1'b0, st_next.d} + 17'd1;
                st_next.rnum = {d1, 16'h0000} - {16'h0000, d1};
                st_next.m    = (cfg.region_width < cfg.region_depth) ?
                               cfg.region_width : cfg.region_depth;
            end
        end
        else if (k >= ST_AXDIV && k < ST_AXDIV + AXDIV_STEPS)
        begin : g_axdiv
            logic [32:0] sx;
            logic [32:0] sz;
            always_comb
            begin
                st_next = pipe_q[k-1];
                sx      = {st_next.remx, 1'b0};
                sz      = {st_next.remz, 1'b0};
                if (sx >= {1'b0, st_next.divx})
                begin
                    st_next.remx = 32'(sx - {1'b0, st_next.divx});
                    st_next.qx   = {st_next.qx[30:0], 1'b1};
                end
                else
                begin
                    st_next.remx = sx[31:0];
                    st_next.qx   = {st_next.qx[30:0], 1'b0};
                end
                if (sz >= {1'b0, st_next.divz})
                begin
                    st_next.remz = 32'(sz - {1'b0, st_next.divz});
                    st_next.qz   = {st_next.qz[30:0], 1'b1};
                end
                else
                begin
                    st_next.remz = sz[31:0];
                    st_next.qz   = {st_next.qz[30:0], 1'b0};
                end
            end
        end
        else if (k == ST_SUM)
        begin : g_sum
            logic [32:0] r2sum;
            always_comb
            begin
                st_next         = pipe_q[k-1];
                r2sum           = {1'b0, st_next.qx} + {1'b0, st_next.qz};
                st_next.outside = r2sum[32];
                st_next.r2      = r2sum[31:0];
                st_next.srem    = 18'd0;
                st_next.root    = 16'd0;
            end
        end
        else if (k >= ST_SQRT && k < ST_SQRT + SQRT_STEPS)
        begin : g_sqrt
            localparam int J = k - ST_SQRT;
            logic [19:0] rsh;
            logic [19:0] trial;
            always_comb
            begin
                st_next = pipe_q[k-1];
                rsh     = {st_next.srem, st_next.r2[31-2*J -: 2]};
                trial   = {2'b00, st_next.root, 2'b01};
                if (rsh >= trial)
                begin
                    st_next.srem = 18'(rsh - trial);
                    st_next.root = {st_next.root[14:0], 1'b1};
                end
                else
                begin
                    st_next.srem = rsh[17:0];
                    st_next.root = {st_next.root[14:0], 1'b0};
                end
            end
        end
        else if (k == ST_INWARD)
        begin : g_inward
            logic [16:0] diff;
            logic [32:0] prod;
            always_comb
            begin
                st_next        = pipe_q[k-1];
                diff           = 17'h10000 - {1'b0, st_next.root};
                prod           = 33'(diff) * 33'(st_next.m);
                st_next.inward = prod[32:1];
            end
        end
        else if (k == ST_PREP)
        begin : g_prep
            logic [48:0] nsum;
            always_comb
            begin
                st_next      = pipe_q[k-1];
                st_next.full = st_next.inward >= {cfg.feather_cells, 16'h0000};
                nsum = {1'b0, st_next.inward, 16'h0000} - {17'h00000, st_next.inward}
                       + {18'h00000, cfg.feather_cells, 15'h0000};
                if (cfg.mask_shape)
                begin
                    st_next.num = nsum[48:16];
                    st_next.den = {1'b0, cfg.feather_cells};
                end
                else
                begin
                    st_next.num = st_next.rnum;
                    st_next.den = {1'b0, cfg.feather_cells} + 17'd1;
                end
                st_next.frem = st_next.num[32:16];
                st_next.fq   = 16'd0;
            end
        end
        else if (k >= ST_FDIV && k < ST_FDIV + FDIV_STEPS)
        begin : g_fdiv
            localparam int J = k - ST_FDIV;
            logic [17:0] fsh;
            always_comb
            begin
                st_next = pipe_q[k-1];
                fsh     = {st_next.frem, st_next.num[15-J]};
                if (fsh >= {1'b0, st_next.den})
                begin
                    st_next.frem = 17'(fsh - {1'b0, st_next.den});
                    st_next.fq   = {st_next.fq[14:0], 1'b1};
                end
                else
                begin
                    st_next.frem = fsh[16:0];
                    st_next.fq   = {st_next.fq[14:0], 1'b0};
                end
            end
        end
        else if (k == ST_WEIGHT)
        begin : g_weight
            always_comb
            begin
                st_next = pipe_q[k-1];
                if (!st_next.in_rgn)
                begin
                    st_next.w = 16'd0;
                end
                else if (cfg.mask_shape)
                begin
                    if (st_next.outside)
                    begin
                        st_next.w = 16'd0;
                    end
                    else if (cfg.feather_cells == 16'd0 || st_next.full)
                    begin
                        st_next.w = FULL_WEIGHT;
                    end
                    else
                    begin
                        st_next.w = st_next.fq;
                    end
                end
                else if (cfg.feather_cells == 16'd0 || st_next.d >= cfg.feather_cells)
                begin
                    st_next.w = FULL_WEIGHT;
                end
                else
                begin
                    st_next.w = st_next.fq;
                end
            end
        end
        else if (k == ST_BLEND)
        begin : g_blend
            logic [15:0] tgt;
            always_comb
            begin
                st_next = pipe_q[k-1];
                case (cfg.blend_mode)
                    MODE_REPLACE: tgt = st_next.gen;
                    MODE_RAISE:   tgt = (st_next.src > st_next.gen) ? st_next.src : st_next.gen;
                    MODE_LOWER:   tgt = (st_next.src < st_next.gen) ? st_next.src : st_next.gen;
                    default:      tgt = st_next.src;
                endcase
                st_next.v = 32'(32'(st_next.src) * 32'(FULL_WEIGHT - st_next.w)
                                + 32'(tgt) * 32'(st_next.w) + 32'd32767);
            end
        end
        else
        begin : g_result
            logic [15:0] q0;
            logic [16:0] r17;
            always_comb
            begin
                st_next     = pipe_q[k-1];
                q0          = st_next.v[31:16];
                r17         = {1'b0, st_next.v[15:0]} + {1'b0, q0};
                st_next.res = q0 + 16'(r17 >= 17'd65535) + 16'(r17 >= 17'd131070);
            end
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                st_reg <= st_next;
            end
        end

        assign pipe_q[k] = st_reg;
    end

    assign out_vld  = vld_reg[NUM_STAGES-1];
    assign out_data = {pipe_q[NUM_STAGES-1].w, pipe_q[NUM_STAGES-1].res};
    assign out_user = {pipe_q[NUM_STAGES-1].res != pipe_q[NUM_STAGES-1].src,
                       pipe_q[NUM_STAGES-1].w != 16'd0 && pipe_q[NUM_STAGES-1].w != FULL_WEIGHT,
                       pipe_q[NUM_STAGES-1].w != 16'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (m_tready || !main_vld_reg)
        begin
            if (skid_vld_reg)
            begin
                main_vld_reg <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                main_vld_reg <= out_vld;
            end
        end
        else if (out_vld && !skid_vld_reg)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !main_vld_reg)
        begin
            main_data_reg <= skid_vld_reg ? skid_data_reg : out_data;
            main_user_reg <= skid_vld_reg ? skid_user_reg : out_user;
        end
        else if (!skid_vld_reg)
        begin
            skid_data_reg <= out_data;
            skid_user_reg <= out_user;
        end
    end

    assign m_tvalid = main_vld_reg;
    assign m_tdata  = main_data_reg;
    assign m_tuser  = main_user_reg;

endmodule

`default_nettype wire

### design/mhb_checker.sv
`default_nettype none

module mhb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser
);

    // A word that waits on the output side stays as it was.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // The masked flag follows the weight.
    a_masked: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] == (m_tdata[31:16] != 16'd0)))
        else $error("masked flag disagrees with weight");

    // The feathered flag marks a weight strictly between zero and full.
    a_feather: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1] == (m_tdata[31:16] != 16'd0 && m_tdata[31:16] != 16'hFFFF)))
        else $error("feathered flag disagrees with weight");

    // A cell with no weight is never modified.
    a_unmod: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> !m_tuser[2])
        else $error("unmasked cell reported as modified");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind masked_heightmap_blend_top mhb_checker u_mhb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/masked_heightmap_blend_top_tb.sv
`default_nettype none

module masked_heightmap_blend_top_tb;
    import mhb_pkg::*;

    typedef struct {
        logic [15:0] height;
        logic [15:0] weight;
        logic        masked;
        logic        feathered;
        logic        modified;
    } cell_result_t;

    typedef struct {
        logic        shape;
        logic [1:0]  mode;
        logic [15:0] feather;
        logic [15:0] width;
        logic [15:0] depth;
        logic [15:0] x;
        logic [15:0] z;
        logic        inr;
        logic [15:0] src;
        logic [15:0] gen;
        logic        typed;
        logic [15:0] typed_height;
        logic [15:0] typed_weight;
    } cell_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    logic        cur_shape;
    logic [1:0]  cur_mode;
    logic [15:0] cur_feather;
    logic [15:0] cur_width;
    logic [15:0] cur_depth;

    cell_result_t pending_cells[$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    masked_heightmap_blend_top u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitpos;
        root = 64'd0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos = bitpos >> 2;
        while (bitpos != 64'd0)
        begin
            if (v >= root + bitpos)
            begin
                v = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end
            else
                root = root >> 1;
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] axis_radius(input logic [15:0] p, input logic [15:0] size);
        logic [63:0] a;
        if ({p, 1'b1} >= {1'b0, size})
            a = 64'({p, 1'b1}) - 64'(size);
        else
            a = 64'(size) - 64'({p, 1'b1});
        return ((a * a) << 32) / (64'(size) * 64'(size));
    endfunction

    function automatic cell_result_t blend_cell(input logic [15:0] x, input logic [15:0] z,
                                                input logic inr, input logic [15:0] src,
                                                input logic [15:0] gen);
        cell_result_t r;
        logic [63:0] w;
        logic [63:0] d;
        logic [63:0] r2;
        logic [63:0] root;
        logic [63:0] m;
        logic [63:0] inward;
        logic [63:0] fq;
        logic [15:0] target;
        logic [63:0] mix;
        w = 64'd0;
        if (inr && x < cur_width && z < cur_depth)
        begin
            if (!cur_shape)
            begin
                if (cur_feather == 16'd0)
                    w = 64'd65535;
                else
                begin
                    d = 64'(x);
                    if (64'(z) < d) d = 64'(z);
                    if (64'(cur_width - 16'd1 - x) < d) d = 64'(cur_width - 16'd1 - x);
                    if (64'(cur_depth - 16'd1 - z) < d) d = 64'(cur_depth - 16'd1 - z);
                    if (d >= 64'(cur_feather))
                        w = 64'd65535;
                    else
                        w = ((d + 64'd1) * 64'd65535) / (64'(cur_feather) + 64'd1);
                end
            end
            else
            begin
                r2 = axis_radius(x, cur_width) + axis_radius(z, cur_depth);
                if (r2 >= (64'd1 << 32))
                    w = 64'd0;
                else if (cur_feather == 16'd0)
                    w = 64'd65535;
                else
                begin
                    root = int_sqrt(r2);
                    m = (cur_width < cur_depth) ? 64'(cur_width) : 64'(cur_depth);
                    inward = ((64'd65536 - root) * m) >> 1;
                    fq = 64'(cur_feather) << 16;
                    if (inward >= fq)
                        w = 64'd65535;
                    else
                        w = (inward * 64'd65535 + 64'(cur_feather) * 64'd32768) / fq;
                end
            end
        end
        r.height = src;
        if (w != 64'd0)
        begin
            case (cur_mode)
                MODE_REPLACE: target = gen;
                MODE_RAISE:   target = (src > gen) ? src : gen;
                MODE_LOWER:   target = (src < gen) ? src : gen;
                default:      target = src;
            endcase
            mix = (64'(src) * (64'd65535 - w) + 64'(target) * w + 64'd32767) / 64'd65535;
            r.height = mix[15:0];
        end
        r.weight = w[15:0];
        r.masked = (w != 64'd0);
        r.feathered = (w != 64'd0) && (w != 64'd65535);
        r.modified = (r.height != src);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cells.size() == 0)
                report_mismatch("unexpected word, out_height", m_tdata[15:0], 16'd0);
            else
            begin
                want = pending_cells.pop_front();
                if (m_tdata[15:0] != want.height)
                    report_mismatch("out_height", m_tdata[15:0], want.height);
                if (m_tdata[31:16] != want.weight)
                    report_mismatch("mask_weight", m_tdata[31:16], want.weight);
                if (m_tuser[0] != want.masked)
                    report_mismatch("masked", 16'(m_tuser[0]), 16'(want.masked));
                if (m_tuser[1] != want.feathered)
                    report_mismatch("feathered", 16'(m_tuser[1]), 16'(want.feathered));
                if (m_tuser[2] != want.modified)
                    report_mismatch("modified", 16'(m_tuser[2]), 16'(want.modified));
            end
        end
    end

    always @(negedge clk)
    begin
        m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic load_settings(input logic shape, input logic [1:0] mode,
                                 input logic [15:0] feather, input logic [15:0] width,
                                 input logic [15:0] depth);
        wait_drained();
        write_reg(REG_MASK_SHAPE, 32'(shape));
        write_reg(REG_BLEND_MODE, 32'(mode));
        write_reg(REG_FEATHER_CELLS, 32'(feather));
        write_reg(REG_REGION_WIDTH, 32'(width));
        write_reg(REG_REGION_DEPTH, 32'(depth));
        cur_shape = shape;
        cur_mode = mode;
        cur_feather = feather;
        cur_width = width;
        cur_depth = depth;
    endtask

    task automatic send_cell(input logic [15:0] x, input logic [15:0] z, input logic inr,
                             input logic [15:0] src, input logic [15:0] gen,
                             input logic typed, input logic [15:0] th, input logic [15:0] tw);
        cell_result_t want;
        logic taken;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {gen, src, z, x};
        s_tuser = inr;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = s_tready;
        end
        if (typed)
        begin
            want.height = th;
            want.weight = tw;
            want.masked = (tw != 16'd0);
            want.feathered = (tw != 16'd0) && (tw != 16'hFFFF);
            want.modified = (th != src);
        end
        else
            want = blend_cell(x, z, inr, src, gen);
        pending_cells = {pending_cells, want};
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    initial
    begin
        #8000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        cell_row_t rows[$];
        cell_row_t row;
        logic [15:0] x;
        logic [15:0] z;
        logic inr;
        logic [15:0] w_cfg;
        logic [15:0] d_cfg;
        int phase;
        int n;

        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        cur_shape = 1'b0;
        cur_mode = MODE_REPLACE;
        cur_feather = 16'd0;
        cur_width = 16'd1;
        cur_depth = 16'd1;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        rows = '{
            '{0, MODE_REPLACE, 0, 1, 1, 0, 0, 1, 16'd0, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF},
            '{0, MODE_REPLACE, 0, 1, 1, 0, 0, 1, 16'hFFFF, 16'd0, 1, 16'd0, 16'hFFFF},
            '{0, MODE_REPLACE, 0, 1, 1, 0, 0, 0, 16'd1234, 16'd999, 1, 16'd1234, 16'd0},
            '{0, MODE_REPLACE, 0, 1, 1, 1, 0, 1, 16'd77, 16'd5, 1, 16'd77, 16'd0},
            '{0, MODE_REPLACE, 0, 1, 1, 0, 16'hFFFF, 1, 16'd77, 16'd5, 1, 16'd77, 16'd0},
            '{0, MODE_RAISE, 4, 20, 12, 0, 0, 1, 16'd100, 16'd40000, 0, 0, 0},
            '{0, MODE_RAISE, 4, 20, 12, 3, 5, 1, 16'd50000, 16'd100, 0, 0, 0},
            '{0, MODE_RAISE, 4, 20, 12, 19, 11, 1, 16'd0, 16'hFFFF, 0, 0, 0},
            '{0, MODE_RAISE, 4, 20, 12, 10, 6, 1, 16'd300, 16'd9000, 0, 0, 0},
            '{0, MODE_LOWER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 1, 16'hFFFF, 16'd0, 0, 0, 0},
            '{0, MODE_LOWER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE, 1,
              16'd7, 16'd60000, 0, 0, 0},
            '{0, MODE_LOWER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1,
              16'd60000, 16'd7, 0, 0, 0},
            '{1, MODE_REPLACE, 0, 9, 9, 0, 0, 1, 16'd500, 16'd600, 0, 0, 0},
            '{1, MODE_REPLACE, 0, 9, 9, 4, 4, 1, 16'd500, 16'd600, 0, 0, 0},
            '{1, 2'd3, 3, 9, 7, 4, 3, 1, 16'd500, 16'd60000, 0, 0, 0},
            '{1, 2'd3, 3, 9, 7, 1, 3, 1, 16'd500, 16'd60000, 0, 0, 0},
            '{1, MODE_RAISE, 16'hFFFF, 16'hFFFF, 3, 16'h7FFF, 1, 1, 16'd10, 16'd65000, 0, 0, 0},
            '{1, MODE_RAISE, 16'hFFFF, 16'hFFFF, 3, 0, 1, 1, 16'd10, 16'd65000, 0, 0, 0},
            '{0, MODE_REPLACE, 0, 0, 0, 0, 0, 1, 16'd42, 16'd4242, 1, 16'd42, 16'd0},
            '{1, MODE_REPLACE, 0, 0, 0, 0, 0, 1, 16'd42, 16'd4242, 1, 16'd42, 16'd0}
        };

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.shape != cur_shape || row.mode != cur_mode || row.feather != cur_feather
                || row.width != cur_width || row.depth != cur_depth)
            begin
                end_burst();
                load_settings(row.shape, row.mode, row.feather, row.width, row.depth);
            end
            send_cell(row.x, row.z, row.inr, row.src, row.gen,
                      row.typed, row.typed_height, row.typed_weight);
        end
        end_burst();

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (phase == 0)
            begin
                w_cfg = 16'hFFFF;
                d_cfg = 16'hFFFF;
            end
            else if (phase == 1)
            begin
                w_cfg = 16'd1;
                d_cfg = 16'd1;
            end
            else
            begin
                w_cfg = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
                                                    : 16'($urandom_range(1, 40));
                d_cfg = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
                                                    : 16'($urandom_range(1, 40));
            end
            load_settings(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 65535))
                                                      : 16'($urandom_range(0, 8)),
                          w_cfg, d_cfg);
            for (n = 0; n < 75; n++)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    x = 16'($urandom_range(0, cur_width - 1));
                    z = 16'($urandom_range(0, cur_depth - 1));
                    inr = 1'b1;
                end
                else
                begin
                    x = 16'($urandom);
                    z = 16'($urandom);
                    inr = 1'($urandom);
                end
                send_cell(x, z, inr, 16'($urandom), 16'($urandom), 1'b0, 16'd0, 16'd0);
            end
            end_burst();
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
design/mhb_pkg.sv
design/mhb_regs.sv
design/masked_heightmap_blend_top.sv
design/mhb_checker.sv
tb/masked_heightmap_blend_top_tb.sv
